// ----- design/yawpid_pkg.sv -----
// ----------------------------------------------------------------------------
// yawpid_pkg
// Shared widths, register indexes and reset values for the yaw heading PID.
// ----------------------------------------------------------------------------
package yawpid_pkg;

  localparam int unsigned AngleBitsDef = 16;
  localparam int unsigned SumBitsDef   = 32;

  localparam int unsigned FieldW    = 16;
  localparam int unsigned GainW     = 24;
  localparam int unsigned LimitW    = 15;
  localparam int unsigned DeadbandW = 11;
  localparam int unsigned FracBits  = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_OUTPUT_LIMIT = 3'd3,
    REG_DEADBAND     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [GainW-1:0] prop_gain;
    logic signed [GainW-1:0] integ_gain;
    logic signed [GainW-1:0] deriv_gain;
    logic [LimitW-1:0]       output_limit;
    logic [DeadbandW-1:0]    deadband;
  } cfg_t;

  localparam logic signed [GainW-1:0] PropGainRst    = 24'sd14746;
  localparam logic signed [GainW-1:0] IntegGainRst   = 24'sd0;
  localparam logic signed [GainW-1:0] DerivGainRst   = 24'sd44;
  localparam logic [LimitW-1:0]       OutputLimitRst = 15'd2458;
  localparam logic [DeadbandW-1:0]    DeadbandRst    = 11'd18;

endpackage

// ----- design/yawpid_if.sv -----
// ----------------------------------------------------------------------------
// yawpid interfaces
// Valid/ready channels for heading items, result items and register writes.
// ----------------------------------------------------------------------------
interface yawpid_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [yawpid_pkg::FieldW-1:0]  target_angle;
  logic signed [yawpid_pkg::FieldW-1:0]  measured_yaw;

  modport source (output valid, output target_angle, output measured_yaw, input ready);
  modport sink   (input valid, input target_angle, input measured_yaw, output ready);
endinterface

interface yawpid_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [yawpid_pkg::FieldW-1:0]  rate_command;
  logic signed [yawpid_pkg::FieldW-1:0]  heading_error;
  logic                                  settled;

  modport source (output valid, output rate_command, output heading_error, output settled,
                  input ready);
  modport sink   (input valid, input rate_command, input heading_error, input settled,
                  output ready);
endinterface

interface yawpid_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [yawpid_pkg::CfgIdxW-1:0]        index;
  logic [yawpid_pkg::CfgDataW-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/yaw_pid_with_wrap_and_deadband.sv -----
// ----------------------------------------------------------------------------
// yaw_pid_with_wrap_and_deadband
// Yaw heading PID with binary angle wrap, saturating integral and deadband.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one item per sample, target_angle and measured_yaw as binary
//            angles (a full turn is 2^ANGLE_BITS).
//   out_o  : one item per input item: rate_command (Q3.12), the wrapped
//            heading_error and the settled flag, in input order.
//   cfg_i  : register writes (prop_gain, integ_gain, deriv_gain,
//            output_limit, deadband at indexes 0..4); always ready, unknown
//            indexes are dropped. Write only while the block is empty.
// Timing: an accepted item passes the input, error, product, sum and result
//   registers in order. One item per cycle is sustained while out_o.ready
//   is high; error/sum state updates when an item loads the error stage.
// Reset: registers return to their default values, last error and error
//   sum clear, all pipeline stages empty.
// Stall: each stage holds its item while the next is full; in_i.ready drops
//   only once every stage is occupied.
// ----------------------------------------------------------------------------
module yaw_pid_with_wrap_and_deadband #(
  parameter int unsigned ANGLE_BITS = yawpid_pkg::AngleBitsDef,
  parameter int unsigned SUM_BITS   = yawpid_pkg::SumBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  yawpid_cfg_if.sink    cfg_i,
  yawpid_in_if.sink     in_i,
  yawpid_out_if.source  out_o
);

  localparam int unsigned GainW    = yawpid_pkg::GainW;
  localparam int unsigned FracBits = yawpid_pkg::FracBits;
  localparam int unsigned ShW      = (SUM_BITS > FracBits + 1) ? SUM_BITS - FracBits : 1;

  yawpid_pkg::cfg_t                   cfg;

  logic                               err_valid, err_ready;
  logic signed [ANGLE_BITS-1:0]       err_e;
  logic signed [ANGLE_BITS:0]         err_diff;
  logic signed [SUM_BITS-1:0]         err_sum;
  logic                               err_settled;

  logic                               mul_valid, mul_ready;
  logic signed [GainW+ANGLE_BITS-1:0] prod_p;
  logic signed [GainW+ANGLE_BITS:0]   prod_d;
  logic signed [GainW+FracBits:0]     prod_l;
  logic signed [GainW+ShW-1:0]        prod_h;
  logic signed [ANGLE_BITS-1:0]       mul_err;
  logic                               mul_settled;

  yawpid_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  yawpid_err #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .deadband_i (cfg.deadband),
    .valid_o    (err_valid),
    .ready_i    (err_ready),
    .err_o      (err_e),
    .diff_o     (err_diff),
    .sum_o      (err_sum),
    .settled_o  (err_settled)
  );

  yawpid_mult #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_mult (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (err_valid),
    .ready_o   (err_ready),
    .err_i     (err_e),
    .diff_i    (err_diff),
    .sum_i     (err_sum),
    .settled_i (err_settled),
    .valid_o   (mul_valid),
    .ready_i   (mul_ready),
    .prod_p_o  (prod_p),
    .prod_d_o  (prod_d),
    .prod_l_o  (prod_l),
    .prod_h_o  (prod_h),
    .err_o     (mul_err),
    .settled_o (mul_settled)
  );

  yawpid_out #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .limit_i   (cfg.output_limit),
    .valid_i   (mul_valid),
    .ready_o   (mul_ready),
    .prod_p_i  (prod_p),
    .prod_d_i  (prod_d),
    .prod_l_i  (prod_l),
    .prod_h_i  (prod_h),
    .err_i     (mul_err),
    .settled_i (mul_settled),
    .out_o     (out_o)
  );

endmodule

// ----- design/yawpid_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// yawpid_cfg_regs
// Gain, limit and deadband registers, written over the configuration channel.
// ----------------------------------------------------------------------------
module yawpid_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  yawpid_cfg_if.sink         cfg_i,
  output yawpid_pkg::cfg_t   cfg_o
);

  yawpid_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (yawpid_pkg::cfg_idx_e'(cfg_i.index))
        yawpid_pkg::REG_PROP_GAIN: begin
          cfg_d.prop_gain = cfg_i.data[yawpid_pkg::GainW-1:0];
        end
        yawpid_pkg::REG_INTEG_GAIN: begin
          cfg_d.integ_gain = cfg_i.data[yawpid_pkg::GainW-1:0];
        end
        yawpid_pkg::REG_DERIV_GAIN: begin
          cfg_d.deriv_gain = cfg_i.data[yawpid_pkg::GainW-1:0];
        end
        yawpid_pkg::REG_OUTPUT_LIMIT: begin
          cfg_d.output_limit = cfg_i.data[yawpid_pkg::LimitW-1:0];
        end
        yawpid_pkg::REG_DEADBAND: begin
          cfg_d.deadband = cfg_i.data[yawpid_pkg::DeadbandW-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain    <= yawpid_pkg::PropGainRst;
      cfg_q.integ_gain   <= yawpid_pkg::IntegGainRst;
      cfg_q.deriv_gain   <= yawpid_pkg::DerivGainRst;
      cfg_q.output_limit <= yawpid_pkg::OutputLimitRst;
      cfg_q.deadband     <= yawpid_pkg::DeadbandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/yawpid_err.sv -----
// ----------------------------------------------------------------------------
// yawpid_err
// Input register, wrapped heading error, error difference, saturating sum.
// ----------------------------------------------------------------------------
module yawpid_err #(
  parameter int unsigned ANGLE_BITS = yawpid_pkg::AngleBitsDef,
  parameter int unsigned SUM_BITS   = yawpid_pkg::SumBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  yawpid_in_if.sink                            in_i,
  input  logic [yawpid_pkg::DeadbandW-1:0]     deadband_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [ANGLE_BITS-1:0]         err_o,
  output logic signed [ANGLE_BITS:0]           diff_o,
  output logic signed [SUM_BITS-1:0]           sum_o,
  output logic                                 settled_o
);

  localparam int unsigned FieldW = yawpid_pkg::FieldW;
  localparam int unsigned DiffW  = (ANGLE_BITS > FieldW + 1) ? ANGLE_BITS : FieldW + 1;
  localparam int unsigned AccW   = ((SUM_BITS > ANGLE_BITS) ? SUM_BITS : ANGLE_BITS) + 1;
  localparam int unsigned MagW   = (ANGLE_BITS + 1 > yawpid_pkg::DeadbandW) ?
                                   ANGLE_BITS + 1 : yawpid_pkg::DeadbandW;

  logic                          in_v_q;
  logic signed [FieldW-1:0]      tgt_q, meas_q;
  logic                          v_q;
  logic                          load_rdy, in_rdy, load;
  logic signed [ANGLE_BITS-1:0]  last_q, err_d;
  logic signed [ANGLE_BITS:0]    diff_q, diff_d;
  logic signed [SUM_BITS-1:0]    total_q, total_d;
  logic                          settled_q, settled_d;
  logic signed [FieldW:0]        raw_diff;
  logic signed [DiffW-1:0]       raw_ext;
  logic signed [AccW-1:0]        acc;
  logic signed [ANGLE_BITS:0]    err_ext;
  logic [ANGLE_BITS:0]           mag;

  assign load_rdy   = !v_q || ready_i;
  assign in_rdy     = !in_v_q || load_rdy;
  assign load       = load_rdy && in_v_q;
  assign in_i.ready = in_rdy;

  always_comb begin
    raw_diff = (FieldW + 1)'(tgt_q) - (FieldW + 1)'(meas_q);
    raw_ext  = DiffW'(raw_diff);
    err_d    = raw_ext[ANGLE_BITS-1:0];
    err_ext  = (ANGLE_BITS + 1)'(err_d);
    diff_d   = err_ext - (ANGLE_BITS + 1)'(last_q);
    acc      = AccW'(total_q) + AccW'(err_d);
    if (acc[AccW-1:SUM_BITS-1] == '0 || acc[AccW-1:SUM_BITS-1] == '1) begin
      total_d = acc[SUM_BITS-1:0];
    end else begin
      total_d = {acc[AccW-1], {(SUM_BITS - 1){~acc[AccW-1]}}};
    end
    mag       = err_ext[ANGLE_BITS] ? -err_ext : err_ext;
    settled_d = MagW'(mag) < MagW'(deadband_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      v_q     <= 1'b0;
      last_q  <= '0;
      total_q <= '0;
    end else begin
      if (in_rdy) begin
        in_v_q <= in_i.valid;
      end
      if (load_rdy) begin
        v_q <= in_v_q;
      end
      if (load) begin
        last_q  <= err_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      tgt_q  <= in_i.target_angle;
      meas_q <= in_i.measured_yaw;
    end
    if (load) begin
      diff_q    <= diff_d;
      settled_q <= settled_d;
    end
  end

  // state registers double as the stage payload: they only move when the stage loads
  assign valid_o   = v_q;
  assign err_o     = last_q;
  assign sum_o     = total_q;
  assign diff_o    = diff_q;
  assign settled_o = settled_q;

endmodule

// ----- design/yawpid_mult.sv -----
// ----------------------------------------------------------------------------
// yawpid_mult
// Gain products; the error sum is split at the binary point for the I term.
// ----------------------------------------------------------------------------
module yawpid_mult #(
  parameter int unsigned ANGLE_BITS = yawpid_pkg::AngleBitsDef,
  parameter int unsigned SUM_BITS   = yawpid_pkg::SumBitsDef,
  localparam int unsigned GainW     = yawpid_pkg::GainW,
  localparam int unsigned FracBits  = yawpid_pkg::FracBits,
  localparam int unsigned ShW       = (SUM_BITS > FracBits + 1) ? SUM_BITS - FracBits : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  yawpid_pkg::cfg_t                     cfg_i,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [ANGLE_BITS-1:0]         err_i,
  input  logic signed [ANGLE_BITS:0]           diff_i,
  input  logic signed [SUM_BITS-1:0]           sum_i,
  input  logic                                 settled_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [GainW+ANGLE_BITS-1:0]   prod_p_o,
  output logic signed [GainW+ANGLE_BITS:0]     prod_d_o,
  output logic signed [GainW+FracBits:0]       prod_l_o,
  output logic signed [GainW+ShW-1:0]          prod_h_o,
  output logic signed [ANGLE_BITS-1:0]         err_o,
  output logic                                 settled_o
);

  logic                                 v_q, load_rdy, load;
  logic signed [GainW-1:0]              kp, ki, kd;
  logic signed [SUM_BITS-1:0]           sh_full;
  logic signed [ShW-1:0]                sh;
  logic signed [FracBits:0]             sl;
  logic signed [GainW+ANGLE_BITS-1:0]   prod_p_q, prod_p_d;
  logic signed [GainW+ANGLE_BITS:0]     prod_d_q, prod_d_d;
  logic signed [GainW+FracBits:0]       prod_l_q, prod_l_d;
  logic signed [GainW+ShW-1:0]          prod_h_q, prod_h_d;
  logic signed [ANGLE_BITS-1:0]         err_q;
  logic                                 settled_q;

  assign load_rdy = !v_q || ready_i;
  assign load     = load_rdy && valid_i;
  assign ready_o  = load_rdy;

  assign kp = cfg_i.prop_gain;
  assign ki = cfg_i.integ_gain;
  assign kd = cfg_i.deriv_gain;

  always_comb begin
    sh_full  = sum_i >>> FracBits;
    sh       = sh_full[ShW-1:0];
    sl       = $signed({1'b0, sum_i[FracBits-1:0]});
    prod_p_d = kp * err_i;
    prod_d_d = kd * diff_i;
    prod_l_d = ki * sl;
    prod_h_d = ki * sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load_rdy) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_p_q  <= prod_p_d;
      prod_d_q  <= prod_d_d;
      prod_l_q  <= prod_l_d;
      prod_h_q  <= prod_h_d;
      err_q     <= err_i;
      settled_q <= settled_i;
    end
  end

  assign valid_o   = v_q;
  assign prod_p_o  = prod_p_q;
  assign prod_d_o  = prod_d_q;
  assign prod_l_o  = prod_l_q;
  assign prod_h_o  = prod_h_q;
  assign err_o     = err_q;
  assign settled_o = settled_q;

endmodule

// ----- design/yawpid_out.sv -----
// ----------------------------------------------------------------------------
// yawpid_out
// Product sum with floor scaling, then clamp, deadband and result register.
// ----------------------------------------------------------------------------
module yawpid_out #(
  parameter int unsigned ANGLE_BITS = yawpid_pkg::AngleBitsDef,
  parameter int unsigned SUM_BITS   = yawpid_pkg::SumBitsDef,
  localparam int unsigned GainW     = yawpid_pkg::GainW,
  localparam int unsigned FracBits  = yawpid_pkg::FracBits,
  localparam int unsigned ShW       = (SUM_BITS > FracBits + 1) ? SUM_BITS - FracBits : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [yawpid_pkg::LimitW-1:0]        limit_i,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [GainW+ANGLE_BITS-1:0]   prod_p_i,
  input  logic signed [GainW+ANGLE_BITS:0]     prod_d_i,
  input  logic signed [GainW+FracBits:0]       prod_l_i,
  input  logic signed [GainW+ShW-1:0]          prod_h_i,
  input  logic signed [ANGLE_BITS-1:0]         err_i,
  input  logic                                 settled_i,
  yawpid_out_if.source                         out_o
);

  localparam int unsigned FieldW = yawpid_pkg::FieldW;
  localparam int unsigned PW     = ((GainW + ANGLE_BITS + 1 > GainW + FracBits + 1) ?
                                    GainW + ANGLE_BITS + 1 : GainW + FracBits + 1) + 2;
  localparam int unsigned UW     = ((GainW + ShW > PW - FracBits) ?
                                    GainW + ShW : PW - FracBits) + 1;

  logic                          u_v_q, out_v_q;
  logic                          u_rdy, out_rdy, u_load, out_load;
  logic signed [PW-1:0]          part, part_sh;
  logic signed [UW-1:0]          u_q, u_d;
  logic signed [ANGLE_BITS-1:0]  u_err_q;
  logic                          u_settled_q;
  logic signed [UW-1:0]          lim, clamped;
  logic signed [FieldW-1:0]      rate_q, rate_d;
  logic signed [FieldW-1:0]      heading_q;
  logic                          settled_q;

  assign out_rdy  = !out_v_q || out_o.ready;
  assign u_rdy    = !u_v_q || out_rdy;
  assign u_load   = u_rdy && valid_i;
  assign out_load = out_rdy && u_v_q;
  assign ready_o  = u_rdy;

  always_comb begin
    part    = PW'(prod_p_i) + PW'(prod_d_i) + PW'(prod_l_i);
    part_sh = part >>> FracBits;
    u_d     = UW'(prod_h_i) + UW'(part_sh);
  end

  always_comb begin
    lim = $signed(UW'(limit_i));
    priority if (u_q >= lim) begin
      clamped = lim;
    end else if (u_q <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = u_q;
    end
    rate_d = u_settled_q ? '0 : clamped[FieldW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (u_rdy) begin
        u_v_q <= valid_i;
      end
      if (out_rdy) begin
        out_v_q <= u_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (u_load) begin
      u_q         <= u_d;
      u_err_q     <= err_i;
      u_settled_q <= settled_i;
    end
    if (out_load) begin
      rate_q    <= rate_d;
      heading_q <= FieldW'(u_err_q);
      settled_q <= u_settled_q;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.rate_command  = rate_q;
  assign out_o.heading_error = heading_q;
  assign out_o.settled       = settled_q;

endmodule
